// ----- hw/rtl/csr_sparse_matrix_vector_multiply_top_assert.svh -----
// Assertion macros for the sparse matrix-vector block.
// Used by the port checker; needs nothing else.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SMV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smv assertion failed");

// Next-cycle implication, disabled while in reset.
`define SMV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smv assertion failed");

`endif

// ----- hw/rtl/smv_pkg.sv -----
// Shared types and constants for the sparse matrix-vector block.
// No dependencies.
package smv_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int VEC_AW       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [16:0] VEC_LIM = 17'(VECTOR_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NONZERO = 2'd1,
    CMD_EMPTY   = 2'd2
  } smv_cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         vector_index;
    logic signed [31:0] vector_value;
    logic [9:0]         column_index;
    logic signed [31:0] matrix_value;
    logic               row_last;
  } smv_in_t;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [31:0] row_result;
    logic               last_row;
  } smv_out_t;

  typedef struct packed {
    logic               row_end;
    logic               empty_row;
    logic signed [63:0] prod;
  } smv_prod_t;

endpackage

// ----- hw/rtl/smv_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module smv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/smv_mul.sv -----
// Front end: vector store, element read and product stage.
// Depends on smv_pkg and smv_ram.
module smv_mul
  import smv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  smv_in_t   in_data,
  output logic      p_valid,
  input  logic      p_ready,
  output smv_prod_t p_data
);

  logic               en1, en2, acc;
  logic               is_load, is_nz, is_emp;
  logic               wr_ok, rd_ok;
  logic [31:0]        rdata;
  logic signed [31:0] x_val;
  logic signed [63:0] prod;

  logic               v1_r, row_end1_r, empty1_r, xin1_r;
  logic signed [31:0] mval1_r;
  logic               v2_r;
  smv_prod_t          p_r;

  assign en2      = !v2_r || p_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign acc      = in_valid && in_ready;

  always_comb begin
    is_load = 1'b0;
    is_nz   = 1'b0;
    is_emp  = 1'b0;
    case (in_data.command)
      CMD_LOAD:    is_load = 1'b1;
      CMD_NONZERO: is_nz   = 1'b1;
      CMD_EMPTY:   is_emp  = 1'b1;
      default:     ;
    endcase
  end

  assign wr_ok = {7'd0, in_data.vector_index} < VEC_LIM;
  assign rd_ok = {7'd0, in_data.column_index} < VEC_LIM;

  smv_ram #(.WIDTH(32), .DEPTH(VECTOR_DEPTH)) u_vec (
    .clk   (clk),
    .we    (acc && is_load && wr_ok),
    .waddr (VEC_AW'(in_data.vector_index)),
    .wdata (in_data.vector_value),
    .re    (en1),
    .raddr (VEC_AW'(in_data.column_index)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= acc && (is_nz || is_emp);
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      row_end1_r <= is_emp || in_data.row_last;
      empty1_r   <= is_emp;
      xin1_r     <= rd_ok;
      mval1_r    <= in_data.matrix_value;
    end
    if (en2) begin
      p_r.row_end   <= row_end1_r;
      p_r.empty_row <= empty1_r;
      p_r.prod      <= prod;
    end
  end

  assign x_val = xin1_r ? $signed(rdata) : 32'sd0;
  assign prod  = mval1_r * x_val;

  assign p_valid = v2_r;
  assign p_data  = p_r;

endmodule

// ----- hw/rtl/smv_acc.sv -----
// Back end: row sum, row counter, row_count register and output word.
// Depends on smv_pkg.
module smv_acc
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        p_valid,
  output logic        p_ready,
  input  smv_prod_t   p_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output smv_out_t    out_data
);

  logic               en3, en4, go, emit, is_last;
  logic signed [64:0] sum_w;
  logic signed [63:0] new_sum;
  logic signed [31:0] q16;

  logic [15:0]        row_count_r, cur_row_r;
  logic signed [63:0] row_sum_r;
  logic               v3_r, last3_r;
  logic [15:0]        row3_r;
  logic signed [63:0] sum3_r;
  logic               out_valid_r;
  smv_out_t           out_r;

  assign cfg_ready = 1'b1;
  assign en4       = !out_valid_r || out_ready;
  assign en3       = !v3_r || en4;
  assign p_ready   = !p_data.row_end || en3;
  assign go        = p_valid && p_ready;
  assign emit      = go && p_data.row_end;
  assign is_last   = cur_row_r == 16'(row_count_r - 16'd1);

  always_comb begin
    sum_w = {row_sum_r[63], row_sum_r} + {p_data.prod[63], p_data.prod};
    if (sum_w[64] != sum_w[63]) begin
      new_sum = sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      new_sum = sum_w[63:0];
    end
  end

  always_comb begin
    if ((&sum3_r[63:47]) || !(|sum3_r[63:47])) begin
      q16 = sum3_r[47:16];
    end else begin
      q16 = sum3_r[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 16'd1;
      cur_row_r   <= 16'd0;
      row_sum_r   <= 64'sd0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_count_r <= cfg_data;
      end
      if (go) begin
        row_sum_r <= p_data.row_end ? 64'sd0 : new_sum;
      end
      if (emit) begin
        cur_row_r <= is_last ? 16'd0 : 16'(cur_row_r + 16'd1);
      end
      if (en3) begin
        v3_r <= emit;
      end
      if (en4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sum3_r  <= p_data.empty_row ? 64'sd0 : new_sum;
      row3_r  <= cur_row_r;
      last3_r <= is_last;
    end
    if (en4) begin
      out_r.row_index  <= row3_r;
      out_r.row_result <= q16;
      out_r.last_row   <= last3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/csr_sparse_matrix_vector_multiply_top.sv -----
// Top level of the streamed CSR sparse matrix-vector multiplier.
// Depends on smv_pkg, smv_mul and smv_acc.
//
//   channel | direction | word      | handshake
//   in_     | input     | smv_in_t  | in_valid / in_ready
//   out_    | output    | smv_out_t | out_valid / out_ready
//   cfg_    | input     | row_count | cfg_valid / cfg_ready
//
// One word per cycle sustained while out_ready holds high; a row result
// goes through the store read, multiply, accumulate and saturate stages
// once its closing word is taken. Row sum and row counter are the loops.
// Reset clears the row sum, row counter and row_count (to 1); the vector
// store is not cleared. Output stalls back up one stage at a time, bubbles
// are filled, and cfg_ready is always high.
module csr_sparse_matrix_vector_multiply_top
  import smv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  smv_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output smv_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic      p_valid, p_ready;
  smv_prod_t p_data;

  smv_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .p_valid  (p_valid),
    .p_ready  (p_ready),
    .p_data   (p_data)
  );

  smv_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_valid   (p_valid),
    .p_ready   (p_ready),
    .p_data    (p_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/smv_chk.sv -----
// Port checker for the sparse matrix-vector block, bound to the top level.
// Depends on smv_pkg and the assertion macro header.
`include "csr_sparse_matrix_vector_multiply_top_assert.svh"

module smv_chk
  import smv_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input smv_in_t     in_data,
  input logic        out_valid,
  input logic        out_ready,
  input smv_out_t    out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  logic [15:0] rc_r, exp_row_r;
  logic        in_seen;

  assign in_seen = in_valid && in_ready && (in_data.command != CMD_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r      <= 16'd1;
      exp_row_r <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rc_r <= cfg_data;
      end
      if (out_valid && out_ready) begin
        exp_row_r <= out_data.last_row ? 16'd0 : 16'(out_data.row_index + 16'd1);
      end
    end
  end

  `SMV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SMV_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `SMV_ASSERT_NOW(a_last_flag, clk, rst_n, out_valid, out_data.last_row == (out_data.row_index == 16'(rc_r - 16'd1)))
  `SMV_ASSERT_NOW(a_row_order, clk, rst_n, out_valid || in_seen, !out_valid || (out_data.row_index == exp_row_r))

endmodule

bind csr_sparse_matrix_vector_multiply_top smv_chk u_smv_chk (.*);

// ----- test/tb_csr_sparse_matrix_vector_multiply_top.sv -----
// Testbench for csr_sparse_matrix_vector_multiply_top: streams vector loads and CSR rows,
// predicts every row result and checks it field by field against the out_ channel.
// Depends on smv_pkg and the block's RTL only.
module tb_csr_sparse_matrix_vector_multiply_top;
  import smv_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int QUIET_CYCLES = 16;
  localparam int TAIL_CYCLES  = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    bit          is_cfg;
    bit          drain;
    smv_in_t     word;
    logic [15:0] rows;
  } backlog_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  smv_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  smv_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  csr_sparse_matrix_vector_multiply_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state
  logic signed [31:0] x_store [VECTOR_DEPTH];
  logic signed [63:0] acc_sum;
  logic [15:0]        row_now;
  logic [15:0]        rows_cfg;
  smv_out_t           row_results_due [$];

  // Stimulus side
  backlog_t    word_backlog [$];
  bit          loaded_map [VECTOR_DEPTH];
  int          loaded_list [$];
  logic [15:0] gen_row = 16'd0;
  logic [15:0] gen_rows = 16'd1;
  int          mismatches = 0;

  function automatic int pick_wait(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [31:0] q16_floor_sat(logic signed [63:0] s);
    logic signed [63:0] q;
    q = s >>> 16;
    if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic void close_row(logic signed [31:0] value);
    smv_out_t r;
    r.row_index  = row_now;
    r.row_result = value;
    r.last_row   = (row_now == rows_cfg - 16'd1);
    row_results_due.push_back(r);
    row_now = r.last_row ? 16'd0 : row_now + 16'd1;
    acc_sum = '0;
  endfunction

  function automatic void take_word(smv_in_t w);
    logic signed [63:0] a, x, p, s;
    if (w.command == CMD_LOAD) begin
      if (w.vector_index < VECTOR_DEPTH) x_store[w.vector_index] = $signed(w.vector_value);
    end else if (w.command == CMD_NONZERO) begin
      a = $signed(w.matrix_value);
      x = (w.column_index < VECTOR_DEPTH) ? $signed(x_store[w.column_index]) : 64'sd0;
      p = a * x;
      s = acc_sum + p;
      if (!acc_sum[63] && !p[63] && s[63]) s = {1'b0, {63{1'b1}}};
      else if (acc_sum[63] && p[63] && !s[63]) s = {1'b1, 63'd0};
      acc_sum = s;
      if (w.row_last) close_row(q16_floor_sat(acc_sum));
    end else if (w.command == CMD_EMPTY) begin
      close_row(32'sd0);
    end
  endfunction

  // Driver: words and register writes from the backlog, in order
  bit    calm_tx = 1'b0;
  bit    gap_drawn = 1'b0;
  int    gap_left = 0;
  int    quiet = 0;

  always @(posedge clk) begin
    logic     nxt_in, nxt_cfg, ok;
    backlog_t head;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      acc_sum   = '0;
      row_now   = '0;
      rows_cfg  = 16'd1;
      quiet     = 0;
    end else begin
      nxt_in  = in_valid;
      nxt_cfg = cfg_valid;
      if (in_valid && in_ready) begin
        take_word(in_data);
        nxt_in = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        rows_cfg = cfg_data;
        nxt_cfg  = 1'b0;
      end
      if (in_valid || cfg_valid || row_results_due.size() != 0) quiet = 0;
      else if (quiet < 1000) quiet++;
      if (!nxt_in && !nxt_cfg && word_backlog.size() != 0) begin
        if (!gap_drawn) begin
          if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
          gap_left  = pick_wait(calm_tx);
          gap_drawn = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          head = word_backlog[0];
          if (head.is_cfg) ok = (quiet >= QUIET_CYCLES);
          else if (head.drain) ok = (row_results_due.size() == 0);
          else ok = 1'b1;
          if (ok) begin
            void'(word_backlog.pop_front());
            gap_drawn = 1'b0;
            if (head.is_cfg) begin
              cfg_data <= head.rows;
              nxt_cfg = 1'b1;
            end else begin
              in_data <= head.word;
              nxt_in = 1'b1;
            end
          end
        end
      end
      in_valid  <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: check each result word against the oldest prediction
  bit calm_rx = 1'b0;
  int stall_left = 0;
  int results_seen = 0;

  always @(posedge clk) begin
    smv_out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (row_results_due.size() == 0) begin
          $error("unexpected result: row_index %0d row_result %0d last_row %0d",
                 out_data.row_index, out_data.row_result, out_data.last_row);
          mismatches++;
        end else begin
          exp_r = row_results_due.pop_front();
          if (out_data.row_index !== exp_r.row_index) begin
            $error("row_index: expected %0d, got %0d", exp_r.row_index, out_data.row_index);
            mismatches++;
          end
          if (out_data.row_result !== exp_r.row_result) begin
            $error("row_result: expected %0h, got %0h", exp_r.row_result, out_data.row_result);
            mismatches++;
          end
          if (out_data.last_row !== exp_r.last_row) begin
            $error("last_row: expected %0d, got %0d", exp_r.last_row, out_data.last_row);
            mismatches++;
          end
        end
        if (results_seen == 120 || results_seen == 800) begin
          stall_left = HOLD_CYCLES;
        end else begin
          if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
          stall_left = pick_wait(calm_rx);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Stimulus generation
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh00010000;
          3: return 32'shFFFFFFFF;
          default: return 32'sh0;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic smv_in_t junk_word();
    smv_in_t w;
    w.command      = 2'($urandom());
    w.vector_index = 10'($urandom());
    w.vector_value = $urandom();
    w.column_index = 10'($urandom());
    w.matrix_value = $urandom();
    w.row_last     = 1'($urandom());
    return w;
  endfunction

  function automatic void queue_word(smv_in_t w, bit drain);
    backlog_t b;
    b.is_cfg = 1'b0;
    b.drain  = drain;
    b.word   = w;
    b.rows   = '0;
    word_backlog.push_back(b);
  endfunction

  function automatic void advance_gen_row();
    gen_row = (gen_row == gen_rows - 16'd1) ? 16'd0 : gen_row + 16'd1;
  endfunction

  function automatic void queue_load(logic [9:0] idx, logic signed [31:0] val);
    smv_in_t w;
    w = junk_word();
    w.command      = CMD_LOAD;
    w.vector_index = idx;
    w.vector_value = val;
    queue_word(w, 1'b0);
    if (!loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endfunction

  function automatic void queue_nonzero(logic [9:0] col, logic signed [31:0] val, bit last,
                                        bit drain);
    smv_in_t w;
    w = junk_word();
    w.command      = CMD_NONZERO;
    w.column_index = col;
    w.matrix_value = val;
    w.row_last     = last;
    queue_word(w, drain);
    if (last) advance_gen_row();
  endfunction

  function automatic void queue_empty();
    smv_in_t w;
    w = junk_word();
    w.command = CMD_EMPTY;
    queue_word(w, 1'b0);
    advance_gen_row();
  endfunction

  function automatic void queue_spare();
    smv_in_t w;
    w = junk_word();
    w.command = CMD_SPARE;
    queue_word(w, 1'b0);
  endfunction

  function automatic logic [9:0] pick_column();
    return 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  task automatic run_phase(logic [15:0] rows, int items);
    backlog_t b;
    int       made, k, r, drain_at;
    // bring the row counter home (for row counts up to 64) so the new count sees its last row
    if (gen_rows != 16'd0 && gen_rows <= 16'd64)
      while (gen_row != 16'd0) queue_empty();
    b.is_cfg = 1'b1;
    b.drain  = 1'b0;
    b.word   = '0;
    b.rows   = rows;
    word_backlog.push_back(b);
    gen_rows = rows;
    made     = 0;
    drain_at = items / 2;
    while (made < items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        queue_load(10'($urandom()), pick_q16());
        made++;
      end else if (r < 80) begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          queue_nonzero(pick_column(), pick_q16(), i == k - 1, made >= drain_at && i == 0);
        if (made >= drain_at) drain_at = items + 1;
        made += k;
      end else if (r < 88) begin
        queue_empty();
        made++;
      end else if (r < 93) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) queue_nonzero(pick_column(), pick_q16(), 1'b0, 1'b0);
        queue_empty();
        made += k + 1;
      end else if (r < 97) begin
        queue_spare();
      end else begin
        queue_nonzero(pick_column(), pick_q16(), 1'b0, 1'b0);
        made++;
      end
    end
  endtask

  initial begin
    // directed part, row_count at its reset value of one
    queue_load(10'd0, 32'sh7FFFFFFF);
    queue_load(10'd1023, 32'sh80000000);
    queue_load(10'd1, 32'sh00010000);
    queue_load(10'd2, 32'shFFFFFFFF);
    queue_nonzero(10'd1, 32'sh00010000, 1'b1, 1'b0);
    queue_nonzero(10'd1023, 32'sh80000000, 1'b0, 1'b0);
    queue_nonzero(10'd1023, 32'sh80000000, 1'b0, 1'b0);
    queue_nonzero(10'd1023, 32'sh80000000, 1'b1, 1'b0);
    queue_nonzero(10'd1023, 32'sh7FFFFFFF, 1'b0, 1'b0);
    queue_nonzero(10'd1023, 32'sh7FFFFFFF, 1'b0, 1'b0);
    queue_nonzero(10'd1023, 32'sh7FFFFFFF, 1'b1, 1'b0);
    queue_nonzero(10'd2, 32'sh00000001, 1'b1, 1'b0);
    queue_nonzero(10'd0, 32'sh7FFFFFFF, 1'b0, 1'b0);
    queue_empty();
    queue_spare();
    queue_empty();
    queue_nonzero(10'd1, 32'sh0, 1'b1, 1'b1);
    queue_nonzero(10'd0, 32'sh80000000, 1'b1, 1'b0);
    queue_nonzero(10'd2, 32'sh80000000, 1'b1, 1'b0);
    for (int i = 0; i < 24; i++) queue_load(10'($urandom()), pick_q16());

    run_phase(16'd3, 230);
    run_phase(16'd1, 230);
    run_phase(16'd5, 230);
    run_phase(16'd2, 230);
    run_phase(16'd17, 230);
    run_phase(16'd65535, 230);
    run_phase(16'd0, 230);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (word_backlog.size() != 0 || in_valid || cfg_valid || row_results_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
